[rtl/swhsr_pkg.sv]
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader package
// Shared types, register indexes, reset values and result codes.
// ----------------------------------------------------------------------------
package swhsr_pkg;

  localparam int unsigned FrameBits = 40;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 24;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexW-1:0] REG_REQUEST_LOW  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_RELEASE_HIGH = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_RESP_TIMEOUT = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_ONE_THRESH   = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_WIDTH_CAP    = 3'd4;

  // Register reset values.
  localparam logic [15:0] RST_REQUEST_LOW  = 16'd18000;
  localparam logic [7:0]  RST_RELEASE_HIGH = 8'd30;
  localparam logic [9:0]  RST_RESP_TIMEOUT = 10'd200;
  localparam logic [7:0]  RST_ONE_THRESH   = 8'd40;
  localparam logic [7:0]  RST_WIDTH_CAP    = 8'd100;

  // Result codes of a finished read.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_LOW   = 3'd1;
  localparam logic [2:0] ERR_NO_HIGH  = 3'd2;
  localparam logic [2:0] ERR_NO_END   = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM = 3'd4;

  // Line drive codes.
  localparam logic [1:0] DRIVE_RELEASE = 2'd0;
  localparam logic [1:0] DRIVE_LOW     = 2'd1;
  localparam logic [1:0] DRIVE_HIGH    = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_REQ_LOW   = 3'd1,
    PH_REQ_HIGH  = 3'd2,
    PH_WAIT_LOW  = 3'd3,
    PH_WAIT_HIGH = 3'd4,
    PH_WAIT_END  = 3'd5,
    PH_BIT_WAIT  = 3'd6,
    PH_BIT_HIGH  = 3'd7
  } phase_e;

  typedef struct packed {
    logic [15:0] request_low;
    logic [7:0]  release_high;
    logic [9:0]  resp_timeout;
    logic [7:0]  one_thresh;
    logic [7:0]  width_cap;
  } cfg_t;

  typedef struct packed {
    phase_e                 phase;
    logic [15:0]            tick;
    logic [5:0]             bit_idx;
    logic [FrameBits-1:0]   frame;
    logic [7:0]             humidity;
    logic [7:0]             temperature;
    logic [2:0]             err;
  } state_t;

endpackage

[rtl/swhsr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Timing registers written through a plain indexed write port.
// ----------------------------------------------------------------------------
module swhsr_cfg_regs
  import swhsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REQUEST_LOW:  cfg_d.request_low  = cfg_data_i;
        REG_RELEASE_HIGH: cfg_d.release_high = cfg_data_i[7:0];
        REG_RESP_TIMEOUT: cfg_d.resp_timeout = cfg_data_i[9:0];
        REG_ONE_THRESH:   cfg_d.one_thresh   = cfg_data_i[7:0];
        REG_WIDTH_CAP:    cfg_d.width_cap    = cfg_data_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_low  <= RST_REQUEST_LOW;
      cfg_q.release_high <= RST_RELEASE_HIGH;
      cfg_q.resp_timeout <= RST_RESP_TIMEOUT;
      cfg_q.one_thresh   <= RST_ONE_THRESH;
      cfg_q.width_cap    <= RST_WIDTH_CAP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/swhsr_step.sv]
// ----------------------------------------------------------------------------
// Read sequencer step
// Next state of the read sequence for one tick of the data line.
// ----------------------------------------------------------------------------
module swhsr_step
  import swhsr_pkg::*;
(
  input  state_t cur_i,
  input  cfg_t   cfg_i,
  input  logic   start_i,
  input  logic   level_i,
  output state_t nxt_o,
  output logic   done_o
);

  logic [15:0]          tick_inc;
  logic                 timeout_hit;
  logic                 fin;
  logic [2:0]           fin_code;
  logic                 end_bit;
  logic [15:0]          end_ticks;
  logic                 bit_val;
  logic [FrameBits-1:0] frame_new;
  logic [5:0]           idx_new;
  logic [7:0]           sum;

  assign tick_inc    = cur_i.tick + 16'd1;
  assign timeout_hit = tick_inc > {6'd0, cfg_i.resp_timeout};

  always_comb begin
    nxt_o     = cur_i;
    done_o    = 1'b0;
    fin       = 1'b0;
    fin_code  = ERR_NONE;
    end_bit   = 1'b0;
    end_ticks = '0;
    bit_val   = 1'b0;
    frame_new = cur_i.frame;
    idx_new   = cur_i.bit_idx;
    sum       = '0;

    case (cur_i.phase)
      PH_IDLE: begin
        if (start_i) begin
          nxt_o.phase = PH_REQ_LOW;
          nxt_o.tick  = 16'd1;
        end
      end
      PH_REQ_LOW: begin
        if (cur_i.tick >= cfg_i.request_low) begin
          nxt_o.phase = PH_REQ_HIGH;
          nxt_o.tick  = 16'd1;
        end else begin
          nxt_o.tick = tick_inc;
        end
      end
      PH_REQ_HIGH: begin
        if (cur_i.tick >= {8'd0, cfg_i.release_high}) begin
          nxt_o.phase = PH_WAIT_LOW;
          nxt_o.tick  = '0;
        end else begin
          nxt_o.tick = tick_inc;
        end
      end
      PH_WAIT_LOW: begin
        if (!level_i) begin
          nxt_o.phase = PH_WAIT_HIGH;
          nxt_o.tick  = '0;
        end else begin
          nxt_o.tick = tick_inc;
          fin        = timeout_hit;
          fin_code   = ERR_NO_LOW;
        end
      end
      PH_WAIT_HIGH: begin
        if (level_i) begin
          nxt_o.phase = PH_WAIT_END;
          nxt_o.tick  = '0;
        end else begin
          nxt_o.tick = tick_inc;
          fin        = timeout_hit;
          fin_code   = ERR_NO_HIGH;
        end
      end
      PH_WAIT_END: begin
        if (!level_i) begin
          nxt_o.phase   = PH_BIT_WAIT;
          nxt_o.tick    = '0;
          nxt_o.bit_idx = '0;
          nxt_o.frame   = '0;
        end else begin
          nxt_o.tick = tick_inc;
          fin        = timeout_hit;
          fin_code   = ERR_NO_END;
        end
      end
      PH_BIT_WAIT: begin
        if (level_i) begin
          nxt_o.phase = PH_BIT_HIGH;
          nxt_o.tick  = 16'd1;
          // A zero cap ends the bit on its first high tick.
          end_bit     = (cfg_i.width_cap == 8'd0);
          end_ticks   = 16'd1;
        end
      end
      PH_BIT_HIGH: begin
        if (level_i) begin
          nxt_o.tick = tick_inc;
          end_bit    = tick_inc > {8'd0, cfg_i.width_cap};
          end_ticks  = tick_inc;
        end else begin
          end_bit   = 1'b1;
          end_ticks = cur_i.tick;
        end
      end
      default: begin
        nxt_o.phase = PH_IDLE;
        nxt_o.tick  = '0;
      end
    endcase

    if (end_bit) begin
      bit_val       = end_ticks > {8'd0, cfg_i.one_thresh};
      frame_new     = {cur_i.frame[FrameBits-2:0], bit_val};
      idx_new       = cur_i.bit_idx + 6'd1;
      nxt_o.frame   = frame_new;
      nxt_o.bit_idx = idx_new;
      nxt_o.tick    = '0;
      if (idx_new >= 6'(FrameBits)) begin
        sum = frame_new[39:32] + frame_new[31:24] + frame_new[23:16] + frame_new[15:8];
        fin = 1'b1;
        if (sum != frame_new[7:0]) begin
          fin_code = ERR_CHECKSUM;
        end else begin
          fin_code          = ERR_NONE;
          nxt_o.humidity    = frame_new[39:32];
          nxt_o.temperature = frame_new[23:16];
        end
      end else begin
        nxt_o.phase = PH_BIT_WAIT;
      end
    end

    if (fin) begin
      nxt_o.err   = fin_code;
      nxt_o.phase = PH_IDLE;
      nxt_o.tick  = '0;
      done_o      = 1'b1;
    end
  end

endmodule

[rtl/single_wire_humidity_sensor_reader.sv]
// Latency: a result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle unless the output stalls; the sequencer updates its
// state in a single pass per tick and one result register holds the outgoing item.
// Reset: asynchronous, active low; the sequence returns to idle, the holds clear
// to zero and the timing registers take their default values.
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader
// Drives the request pulse on a single-wire sensor line, checks the sensor's
// response timing, decodes the 40-bit frame and verifies its checksum.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader
  import swhsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Tick input: one item per microsecond sample of the data line.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // Fields from bit 0: start_read[0], line_level[1], zero fill [7:2].
  input  logic [InDataW-1:0]   s_axis_tdata_i,
  // Result output: one item per tick.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // Fields from bit 0: line_drive[1:0], busy_res[2], done_res[3],
  // error_code[6:4], humidity[14:7], temperature[22:15], zero fill [23].
  output logic [OutDataW-1:0]  m_axis_tdata_o
);

  cfg_t   cfg;
  state_t state_q, state_d;
  logic   done;
  logic   in_acc;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_q, out_d;
  logic [1:0]          drive;

  swhsr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swhsr_step u_step (
    .cur_i   (state_q),
    .cfg_i   (cfg),
    .start_i (s_axis_tdata_i[0]),
    .level_i (s_axis_tdata_i[1]),
    .nxt_o   (state_d),
    .done_o  (done)
  );

  // A new tick is taken whenever the result register is empty or is being
  // emptied in the same cycle, so the stream runs at one item per cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // The result shows the state after the tick.
  always_comb begin
    case (state_d.phase)
      PH_REQ_LOW:  drive = DRIVE_LOW;
      PH_REQ_HIGH: drive = DRIVE_HIGH;
      default:     drive = DRIVE_RELEASE;
    endcase
    out_d = {1'b0, state_d.temperature, state_d.humidity, state_d.err, done,
             (state_d.phase != PH_IDLE), drive};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_IDLE;
      state_q.tick        <= '0;
      state_q.bit_idx     <= '0;
      state_q.frame       <= '0;
      state_q.humidity    <= '0;
      state_q.temperature <= '0;
      state_q.err         <= ERR_NONE;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  // A finishing tick always leaves the sequence idle.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3] |-> !m_axis_tdata_o[2])
    else $error("done result while still busy");

  // The stored result code only changes on a finishing tick.
  a_err_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (state_d.err != state_q.err) |-> done)
    else $error("error code changed without a finished read");

  // The bit counter never runs past the frame length.
  a_bit_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_idx <= 6'(FrameBits))
    else $error("bit index beyond frame length");
`endif

endmodule

[test/single_wire_humidity_sensor_reader_tb.sv]
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader testbench
// Plays the sensor side of the data line one microsecond tick at a time,
// predicts every result item with a tick-level model of the read sequence,
// and compares each result field by field while both stream sides stall.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_tb;
  import swhsr_pkg::*;

  // Each side stalls in about this many cycles of a hundred.
  localparam int unsigned IdlePct     = 17;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned StallLimit  = 2000;
  // The random part runs until the whole run has sent this many ticks.
  localparam int unsigned TotalTicks  = 850;
  // Only the first mismatches are printed; the rest are counted.
  localparam int unsigned MaxReports  = 40;

  // What the start flag does while a read is already running.
  typedef enum logic [1:0] {
    START_LOW,
    START_HIGH,
    START_RANDOM
  } busy_start_e;

  // One result item, fields from the top bit down.
  typedef struct packed {
    logic       fill;
    logic [7:0] temperature;
    logic [7:0] humidity;
    logic [2:0] err;
    logic       done;
    logic       busy;
    logic [1:0] drive;
  } reading_t;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [InDataW-1:0]   in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OutDataW-1:0]  out_data;

  // Tick-level model of the block: its timing registers and its read state.
  cfg_t   timing;
  state_t sensor;
  logic   read_done;

  reading_t    expected_results[$];
  reading_t    seen_item;
  reading_t    wanted_item;
  int unsigned ticks_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_cycles  = 0;
  int unsigned reads_by_code[8];
  bit          steady_flow   = 1'b0;
  busy_start_e busy_start    = START_RANDOM;

  single_wire_humidity_sensor_reader DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Read sequence model
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    timing = '{request_low: RST_REQUEST_LOW, release_high: RST_RELEASE_HIGH,
               resp_timeout: RST_RESP_TIMEOUT, one_thresh: RST_ONE_THRESH,
               width_cap: RST_WIDTH_CAP};
    sensor = '0;
    sensor.phase = PH_IDLE;
    read_done = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      REG_REQUEST_LOW:  timing.request_low  = val;
      REG_RELEASE_HIGH: timing.release_high = val[7:0];
      REG_RESP_TIMEOUT: timing.resp_timeout = val[9:0];
      REG_ONE_THRESH:   timing.one_thresh   = val[7:0];
      REG_WIDTH_CAP:    timing.width_cap    = val[7:0];
      default: ;
    endcase
  endfunction

  // A read ends: the code is kept and the sequence returns to idle.
  function automatic void finish_read(logic [2:0] code);
    sensor.err   = code;
    sensor.phase = PH_IDLE;
    sensor.tick  = '0;
    read_done    = 1'b1;
  endfunction

  // The checksum is the low byte of the sum of the four data bytes. Only a
  // good frame updates the humidity and temperature holds.
  function automatic void check_frame();
    logic [7:0] sum;
    sum = sensor.frame[39:32] + sensor.frame[31:24] + sensor.frame[23:16] +
          sensor.frame[15:8];
    if (sum != sensor.frame[7:0]) begin
      finish_read(ERR_CHECKSUM);
    end else begin
      sensor.humidity    = sensor.frame[39:32];
      sensor.temperature = sensor.frame[23:16];
      finish_read(ERR_NONE);
    end
  endfunction

  // A high pulse has been measured: shift in its bit, MSB first.
  function automatic void close_bit();
    logic one;
    one = sensor.tick > timing.one_thresh;
    sensor.frame   = {sensor.frame[FrameBits-2:0], one};
    sensor.bit_idx = sensor.bit_idx + 6'd1;
    sensor.tick    = '0;
    if (sensor.bit_idx >= FrameBits) begin
      check_frame();
    end else begin
      sensor.phase = PH_BIT_WAIT;
    end
  endfunction

  // Response phases: the tick that shows the awaited level only moves on;
  // every other tick counts toward the timeout.
  function automatic void await_level(logic level, logic wanted, phase_e nxt,
                                      logic [2:0] code);
    if (level == wanted) begin
      sensor.phase = nxt;
      sensor.tick  = '0;
      if (nxt == PH_BIT_WAIT) begin
        sensor.bit_idx = '0;
        sensor.frame   = '0;
      end
    end else begin
      sensor.tick = sensor.tick + 16'd1;
      if (sensor.tick > timing.resp_timeout) finish_read(code);
    end
  endfunction

  function automatic reading_t predict_tick(logic start, logic level);
    reading_t r;
    read_done = 1'b0;
    case (sensor.phase)
      PH_IDLE: begin
        if (start) begin
          sensor.phase = PH_REQ_LOW;
          sensor.tick  = 16'd1;
        end
      end
      PH_REQ_LOW: begin
        if (sensor.tick >= timing.request_low) begin
          sensor.phase = PH_REQ_HIGH;
          sensor.tick  = 16'd1;
        end else begin
          sensor.tick = sensor.tick + 16'd1;
        end
      end
      PH_REQ_HIGH: begin
        if (sensor.tick >= timing.release_high) begin
          sensor.phase = PH_WAIT_LOW;
          sensor.tick  = '0;
        end else begin
          sensor.tick = sensor.tick + 16'd1;
        end
      end
      PH_WAIT_LOW:  await_level(level, 1'b0, PH_WAIT_HIGH, ERR_NO_LOW);
      PH_WAIT_HIGH: await_level(level, 1'b1, PH_WAIT_END, ERR_NO_HIGH);
      PH_WAIT_END:  await_level(level, 1'b0, PH_BIT_WAIT, ERR_NO_END);
      PH_BIT_WAIT: begin
        // The first high tick already counts, so a zero cap ends the bit here.
        if (level) begin
          sensor.phase = PH_BIT_HIGH;
          sensor.tick  = 16'd1;
          if (sensor.tick > timing.width_cap) close_bit();
        end
      end
      PH_BIT_HIGH: begin
        if (level) begin
          sensor.tick = sensor.tick + 16'd1;
          if (sensor.tick > timing.width_cap) close_bit();
        end else begin
          close_bit();
        end
      end
      default: begin
        sensor.phase = PH_IDLE;
        sensor.tick  = '0;
      end
    endcase
    r.fill        = 1'b0;
    r.temperature = sensor.temperature;
    r.humidity    = sensor.humidity;
    r.err         = sensor.err;
    r.done        = read_done;
    r.busy        = sensor.phase != PH_IDLE;
    r.drive       = (sensor.phase == PH_REQ_LOW)  ? DRIVE_LOW :
                    (sensor.phase == PH_REQ_HIGH) ? DRIVE_HIGH : DRIVE_RELEASE;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    end
  endtask

  // The receiver stalls at random unless a steady stretch is running.
  always @(posedge clk_i) begin
    out_ready <= steady_flow || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (out_valid && out_ready) begin
        seen_item = out_data;
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("with nothing expected", seen_item, 0);
        end else begin
          wanted_item = expected_results.pop_front();
          if (seen_item.drive !== wanted_item.drive)
            report_mismatch("line_drive", seen_item.drive, wanted_item.drive);
          if (seen_item.busy !== wanted_item.busy)
            report_mismatch("busy", seen_item.busy, wanted_item.busy);
          if (seen_item.done !== wanted_item.done)
            report_mismatch("done", seen_item.done, wanted_item.done);
          if (seen_item.err !== wanted_item.err)
            report_mismatch("error_code", seen_item.err, wanted_item.err);
          if (seen_item.humidity !== wanted_item.humidity)
            report_mismatch("humidity", seen_item.humidity, wanted_item.humidity);
          if (seen_item.temperature !== wanted_item.temperature)
            report_mismatch("temperature", seen_item.temperature,
                            wanted_item.temperature);
          if (seen_item.fill !== wanted_item.fill)
            report_mismatch("zero fill", seen_item.fill, wanted_item.fill);
          if (wanted_item.done) reads_by_code[wanted_item.err]++;
        end
      end
      if (stall_cycles >= StallLimit) begin
        $display("No handshake for %0d cycles, %0d results still expected.",
                 stall_cycles, expected_results.size());
        $display("single_wire_humidity_sensor_reader verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Start flag for the next tick. While idle it stays low so that a read only
  // begins where the test wants one; while busy it must be ignored.
  function automatic logic busy_start_bit();
    if (sensor.phase == PH_IDLE) return 1'b0;
    case (busy_start)
      START_HIGH: return 1'b1;
      START_LOW:  return 1'b0;
      default:    return 1'($urandom_range(1));
    endcase
  endfunction

  // Sends one tick item and records what the block must answer. The sender
  // idles at random before the item unless a steady stretch is running.
  task automatic send_tick(input logic start, input logic level);
    while (!steady_flow && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {{(InDataW-2){1'b0}}, level, start};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    expected_results.push_back(predict_tick(start, level));
    ticks_sent++;
  endtask

  task automatic send_run(input logic level, input int unsigned count);
    repeat (count) send_tick(busy_start_bit(), level);
  endtask

  // Stops sending and lets every expected result come back, so that the block
  // is quiet before a register write.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input int unsigned req, input int unsigned rel,
                            input int unsigned tmo, input int unsigned thr,
                            input int unsigned cap);
    wait_results();
    write_reg(REG_REQUEST_LOW,  CfgDataW'(req));
    write_reg(REG_RELEASE_HIGH, CfgDataW'(rel));
    write_reg(REG_RESP_TIMEOUT, CfgDataW'(tmo));
    write_reg(REG_ONE_THRESH,   CfgDataW'(thr));
    write_reg(REG_WIDTH_CAP,    CfgDataW'(cap));
  endtask

  // Small random timing keeps reads short so that many fit in the run.
  task automatic random_timing();
    int unsigned thr;
    thr = $urandom_range(3, 1);
    set_timing(($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1),
               $urandom_range(4, 1), $urandom_range(8, 1), thr,
               $urandom_range(thr + 4, thr + 1));
  endtask

  // Whatever state the block is in, steers the line so that the read ends:
  // a wrong level in a response phase times out, and alternating levels in
  // the data phase close one bit after another.
  task automatic to_idle();
    logic lvl;
    while (sensor.phase != PH_IDLE) begin
      case (sensor.phase)
        PH_WAIT_LOW, PH_WAIT_END, PH_BIT_WAIT: lvl = 1'b1;
        PH_WAIT_HIGH, PH_BIT_HIGH:             lvl = 1'b0;
        default:                               lvl = 1'($urandom_range(1));
      endcase
      send_tick(busy_start_bit(), lvl);
    end
  endtask

  // Starts a read and sends ticks with random line levels until the request
  // pulse is over and the line has been released.
  task automatic begin_read();
    to_idle();
    send_tick(1'b1, 1'($urandom_range(1)));
    while (sensor.phase == PH_REQ_LOW || sensor.phase == PH_REQ_HIGH) begin
      send_tick(busy_start_bit(), 1'($urandom_range(1)));
    end
  endtask

  // Sensor response: the line stays high d0 ticks more, is pulled low for
  // d1 ticks more, is high d2 ticks more and then falls into the data phase.
  task automatic answer_request(input int unsigned d0, input int unsigned d1,
                                input int unsigned d2);
    send_run(1'b1, d0);
    send_run(1'b0, d1 + 1);
    send_run(1'b1, d2 + 1);
    send_tick(busy_start_bit(), 1'b0);
  endtask

  // Forty high pulses, MSB first, each followed by a low gap. A zero is at
  // most one_threshold ticks wide and a one is wider but within the cap. The
  // bit at index stretch, if any, is held high past the cap.
  task automatic send_bits(input logic [FrameBits-1:0] frame, input int unsigned lo_max,
                           input int stretch);
    int unsigned width;
    for (int i = FrameBits - 1; i >= 0; i--) begin
      if (i == stretch) begin
        width = timing.width_cap + 1 + $urandom_range(3);
      end else if (frame[i]) begin
        width = $urandom_range(timing.width_cap, timing.one_thresh + 1);
      end else begin
        width = $urandom_range(timing.one_thresh, 1);
      end
      send_run(1'b1, width);
      send_run(1'b0, $urandom_range(lo_max, 1));
    end
  endtask

  task automatic full_read(input logic [FrameBits-1:0] frame, input int unsigned d0,
                           input int unsigned d1, input int unsigned d2,
                           input int unsigned lo_max);
    begin_read();
    answer_request(d0, d1, d2);
    send_bits(frame, lo_max, -1);
  endtask

  // Holds the wrong level in the response phase that the code names, one tick
  // longer than the timeout allows.
  task automatic fail_in_phase(input logic [2:0] code);
    begin_read();
    if (code != ERR_NO_LOW) send_tick(busy_start_bit(), 1'b0);
    if (code == ERR_NO_END) send_tick(busy_start_bit(), 1'b1);
    send_run((code == ERR_NO_HIGH) ? 1'b0 : 1'b1, timing.resp_timeout + 1);
  endtask

  function automatic logic [FrameBits-1:0] build_frame(logic [7:0] hum, logic [7:0] hum_frac,
                                                       logic [7:0] temp, logic [7:0] temp_frac,
                                                       logic corrupt);
    logic [7:0] sum;
    sum = hum + hum_frac + temp + temp_frac;
    if (corrupt) sum = sum ^ (8'd1 << $urandom_range(7));
    return {hum, hum_frac, temp, temp_frac, sum};
  endfunction

  function automatic logic [FrameBits-1:0] random_frame(logic corrupt);
    return build_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), corrupt);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle ticks right after reset: released line, zero holds, no read started.
  task automatic test_idle_after_reset();
    repeat (6) send_tick(1'b0, 1'($urandom_range(1)));
  endtask

  // A read with the timing registers at their reset values. The request pulse
  // is cut short by a register write, the release high lasts its default
  // length, and the first response phase runs well inside the default timeout
  // until a zero timeout ends it.
  task automatic test_default_timing();
    send_tick(1'b1, 1'b1);
    send_run(1'b1, 4);
    wait_results();
    write_reg(REG_REQUEST_LOW, CfgDataW'(1));
    while (sensor.phase == PH_REQ_LOW || sensor.phase == PH_REQ_HIGH) begin
      send_tick(busy_start_bit(), 1'($urandom_range(1)));
    end
    send_run(1'b1, 5);
    wait_results();
    write_reg(REG_RESP_TIMEOUT, CfgDataW'(0));
    send_run(1'b1, 1);
  endtask

  // Every register but the one threshold at its top value: the request pulse
  // and the release high count inside the widest limits until a write shortens
  // each, and a response phase well inside the widest timeout then fails once
  // the timeout is lowered.
  task automatic test_extreme_timing();
    set_timing(65535, 255, 1023, 254, 255);
    send_tick(1'b1, 1'b1);
    send_run(1'b1, 3);
    wait_results();
    write_reg(REG_REQUEST_LOW, CfgDataW'(1));
    send_run(1'b1, 4);
    wait_results();
    write_reg(REG_RELEASE_HIGH, CfgDataW'(1));
    send_run(1'b1, 1);
    send_run(1'b0, 7);
    wait_results();
    write_reg(REG_RESP_TIMEOUT, CfgDataW'(2));
    send_run(1'b0, 1);
  endtask

  // All registers zero: zero request and release lengths behave as one tick,
  // a zero cap ends each bit on its first high tick, and a zero timeout fails
  // on the first tick without the awaited level.
  task automatic test_minimum_timing();
    set_timing(0, 0, 0, 0, 0);
    begin_read();
    answer_request(0, 0, 0);
    repeat (FrameBits) begin
      send_run(1'b1, 1);
      send_run(1'b0, 1);
    end
    fail_in_phase(ERR_NO_LOW);
    fail_in_phase(ERR_NO_HIGH);
    fail_in_phase(ERR_NO_END);
  endtask

  // One tick more than the timeout in a response phase fails with the code of
  // that phase.
  task automatic test_response_timeouts();
    set_timing(3, 2, 5, 2, 4);
    fail_in_phase(ERR_NO_LOW);
    fail_in_phase(ERR_NO_HIGH);
    fail_in_phase(ERR_NO_END);
  endtask

  // A good all-ones frame, whose checksum needs the sum to wrap, then a bad
  // checksum that must leave the holds alone. Every response phase ends right
  // at the timeout, and neither side stalls during this stretch.
  task automatic test_checksum();
    set_timing(2, 1, 3, 1, 2);
    steady_flow = 1'b1;
    full_read(build_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0), 3, 3, 3, 1);
    full_read(random_frame(1'b1), 3, 3, 3, 1);
    steady_flow = 1'b0;
  endtask

  // Start held high through whole reads, including their finishing ticks,
  // and then start held low, which must not matter either.
  task automatic test_start_while_busy();
    set_timing(2, 1, 2, 1, 2);
    busy_start = START_HIGH;
    fail_in_phase(ERR_NO_HIGH);
    fail_in_phase(ERR_NO_END);
    busy_start = START_LOW;
    fail_in_phase(ERR_NO_LOW);
    busy_start = START_RANDOM;
  endtask

  // A line stuck low in the data phase keeps the block busy; a pulse held
  // past the cap splits into extra bits and misaligns the frame.
  task automatic test_line_faults();
    set_timing(2, 1, 3, 1, 2);
    begin_read();
    answer_request(1, 1, 1);
    send_run(1'b0, 20);
    send_bits(random_frame(1'b0), 1, $urandom_range(FrameBits - 1));
    to_idle();
  endtask

  // A register write in the middle of a read takes effect on the next tick.
  task automatic test_config_mid_read();
    set_timing(2, 2, 8, 2, 4);
    begin_read();
    send_run(1'b1, 3);
    wait_results();
    write_reg(REG_RESP_TIMEOUT, CfgDataW'(2));
    send_run(1'b1, 1);
  endtask

  // Mostly well-formed reads with random bytes and timing, some with a bad
  // checksum; the rest are response timeouts, line noise and stretched pulses.
  task automatic test_random_traffic();
    int unsigned pick;
    while (ticks_sent < TotalTicks) begin
      if ($urandom_range(99) < 25) random_timing();
      pick = $urandom_range(99);
      if (pick < 65) begin
        full_read(random_frame($urandom_range(99) < 20),
                  $urandom_range(timing.resp_timeout), $urandom_range(timing.resp_timeout),
                  $urandom_range(timing.resp_timeout), 2);
      end else if (pick < 75) begin
        fail_in_phase(3'($urandom_range(ERR_NO_END, ERR_NO_LOW)));
      end else if (pick < 88) begin
        repeat ($urandom_range(30, 5)) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        to_idle();
      end else begin
        begin_read();
        answer_request(0, 1, 0);
        send_bits(random_frame(1'b0), 2, $urandom_range(FrameBits - 1));
        to_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_after_reset();
    test_default_timing();
    test_extreme_timing();
    test_minimum_timing();
    test_response_timeouts();
    test_checksum();
    test_start_while_busy();
    test_line_faults();
    test_config_mid_read();
    test_random_traffic();

    // Drain, then keep the clock running for anything the block might still send.
    wait_results();
    repeat (4) @(posedge clk_i);

    $display("Run covered %0d ticks from zero to maximum timing, %0d results checked.",
             ticks_sent, results_seen);
    $display("Reads finished: %0d good, %0d checksum errors, %0d/%0d/%0d response timeouts.",
             reads_by_code[ERR_NONE], reads_by_code[ERR_CHECKSUM], reads_by_code[ERR_NO_LOW],
             reads_by_code[ERR_NO_HIGH], reads_by_code[ERR_NO_END]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("single_wire_humidity_sensor_reader verification clean");
    end else begin
      $display("single_wire_humidity_sensor_reader verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/swhsr_pkg.sv
rtl/swhsr_cfg_regs.sv
rtl/swhsr_step.sv
rtl/single_wire_humidity_sensor_reader.sv
test/single_wire_humidity_sensor_reader_tb.sv
